// File: design/swte_pkg.sv
// ----------------------------------------------------------------------------
// swte_pkg - shared types and constants
// Codes, widths and the sequencer state type of the transfer endpoint.
// ----------------------------------------------------------------------------
package swte_pkg;

	localparam int MAX_CHUNKS = 4096;
	localparam int ADDR_W     = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int MAX_RES    = 63;

	localparam logic [CNT_W-1:0]  MAX_CHUNKS_C = CNT_W'(MAX_CHUNKS);
	localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(MAX_CHUNKS - 1);
	localparam logic [5:0]        RES_LAST     = 6'(MAX_RES);
	localparam logic [5:0]        RES_PENULT   = 6'(MAX_RES - 1);
	localparam logic [15:0]       TIMER_MAX    = 16'hFFFF;

	typedef logic [1:0]        opcode_t;
	typedef logic [2:0]        action_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [ADDR_W-1:0] chunk_t;

	localparam opcode_t OP_DATA = 2'd0;
	localparam opcode_t OP_ACK  = 2'd1;
	localparam opcode_t OP_SYN  = 2'd2;
	localparam opcode_t OP_TICK = 2'd3;

	localparam action_t ACT_SEND    = 3'd0;
	localparam action_t ACT_RESEND  = 3'd1;
	localparam action_t ACT_ACK     = 3'd2;
	localparam action_t ACT_SYNACK  = 3'd3;
	localparam action_t ACT_DONE    = 3'd4;

	localparam logic [1:0] CFG_WINDOW  = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_TOTAL   = 2'd2;
	localparam logic [1:0] CFG_ENABLE  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADV_RD,
		ST_ADV_CHK,
		ST_ACK,
		ST_DONE,
		ST_SYNACK,
		ST_NEW,
		ST_RESEND
	} swte_state_t;

endpackage

// File: design/swte_if.sv
// ----------------------------------------------------------------------------
// swte_if - request and result channels
// Valid/ready channels carrying packet events in and transfer actions out.
// ----------------------------------------------------------------------------
interface swte_req_if;
	logic               valid;
	logic               ready;
	swte_pkg::opcode_t  opcode;
	swte_pkg::chunk_t   chunk_id;
	swte_pkg::count_t   acked_count;
	swte_pkg::count_t   announced_total;

	modport source (output valid, output opcode, output chunk_id,
		output acked_count, output announced_total, input ready);
	modport sink (input valid, input opcode, input chunk_id,
		input acked_count, input announced_total, output ready);
endinterface

interface swte_res_if;
	logic               valid;
	logic               ready;
	swte_pkg::action_t  action;
	swte_pkg::count_t   position;
	logic               last;

	modport source (output valid, output action, output position, output last,
		input ready);
	modport sink (input valid, input action, input position, input last,
		output ready);
endinterface

// File: design/sliding_window_transfer_endpoint_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_transfer_endpoint_unit - go-back-N transfer endpoint
// Receiver bitmap with cumulative acknowledge, and a windowed sender.
// ----------------------------------------------------------------------------
// Requests enter on req (DATA, ACK, SYN, millisecond tick); actions leave on
// res, one per cycle at best, with last set on the final action of a request.
// The block takes one request at a time and drops ready while it works.
// ACK requests and ignored requests end in the idle state; an answered SYN
// passes through the SYN-ACK state. DATA sets its bitmap bit, then advances
// the receive base (one bitmap read per cycle) and sends an ACK; a completion
// adds a DONE action and a bitmap clearing pass. A tick sends new chunks or,
// on a timeout, resends from the send base; at most 63 chunks per tick.
// After reset the bitmap is swept clear before ready rises;
// configuration writes are taken at any time, also during the sweep.
// A result waits in an output register while the receiver stalls; the
// sequencer holds its step until that register frees up.
// ----------------------------------------------------------------------------
module sliding_window_transfer_endpoint_unit (
	input  logic              clk,
	input  logic              arst_n,
	swte_req_if.sink          req,
	swte_res_if.source        res,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	swte_pkg::swte_state_t state_q, state_d;

	logic [swte_pkg::ADDR_W-1:0] clr_q, clr_d;
	swte_pkg::count_t            rbase_q, rbase_d;
	swte_pkg::count_t            rtot_q, rtot_d;
	logic                        ract_q, ract_d;
	swte_pkg::count_t            sbase_q, sbase_d;
	swte_pkg::count_t            nts_q, nts_d;
	logic [15:0]                 timer_q, timer_d;
	swte_pkg::count_t            idx_q, idx_d;
	logic [5:0]                  cnt_q, cnt_d;

	logic [5:0]                  win_q, win_d;
	logic [15:0]                 tmo_q, tmo_d;
	swte_pkg::count_t            stot_q, stot_d;
	logic                        sen_q, sen_d;

	logic                        out_valid_q;
	swte_pkg::action_t           out_action_q;
	swte_pkg::count_t            out_pos_q;
	logic                        out_last_q;

	logic                        map_q [swte_pkg::MAX_CHUNKS];
	logic                        rd_q;
	logic                        mem_we;
	logic [swte_pkg::ADDR_W-1:0] mem_waddr;
	logic                        mem_wdata;
	logic [swte_pkg::ADDR_W-1:0] rd_addr;

	logic                        push;
	swte_pkg::action_t           push_action;
	swte_pkg::count_t            push_pos;
	logic                        push_last;
	logic                        slot_free;
	logic                        req_ready;

	logic [swte_pkg::CNT_W:0]    win_lim;
	logic [swte_pkg::CNT_W:0]    nts_inc;
	logic [swte_pkg::CNT_W:0]    idx_inc;
	logic                        can_new;
	logic                        more_new;
	logic                        cmpl;
	logic                        rs_last;

	assign slot_free = !out_valid_q || res.ready;
	assign win_lim   = {1'b0, sbase_q} + {{(swte_pkg::CNT_W-5){1'b0}}, win_q};
	assign nts_inc   = {1'b0, nts_q} + {{swte_pkg::CNT_W{1'b0}}, 1'b1};
	assign idx_inc   = {1'b0, idx_q} + {{swte_pkg::CNT_W{1'b0}}, 1'b1};
	assign can_new   = (cnt_q != swte_pkg::RES_LAST) && (nts_q < stot_q)
		&& ({1'b0, nts_q} < win_lim);
	assign more_new  = (cnt_q != swte_pkg::RES_PENULT) && (nts_inc < {1'b0, stot_q})
		&& (nts_inc < win_lim);
	assign cmpl      = (rtot_q != '0) && (rbase_q >= rtot_q);
	assign rs_last   = (idx_inc >= {1'b0, nts_q}) || (cnt_q == swte_pkg::RES_PENULT);

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		rbase_d     = rbase_q;
		rtot_d      = rtot_q;
		ract_d      = ract_q;
		sbase_d     = sbase_q;
		nts_d       = nts_q;
		timer_d     = timer_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		win_d       = win_q;
		tmo_d       = tmo_q;
		stot_d      = stot_q;
		sen_d       = sen_q;
		mem_we      = 1'b0;
		mem_waddr   = clr_q;
		mem_wdata   = 1'b0;
		rd_addr     = rbase_q[swte_pkg::ADDR_W-1:0];
		push        = 1'b0;
		push_action = swte_pkg::ACT_SEND;
		push_pos    = '0;
		push_last   = 1'b0;
		req_ready   = 1'b0;

		case (state_q)
			swte_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 1'b0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == swte_pkg::ADDR_LAST) begin
					state_d = swte_pkg::ST_IDLE;
				end
			end
			swte_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					case (req.opcode)
						swte_pkg::OP_DATA: begin
							mem_we    = 1'b1;
							mem_waddr = req.chunk_id;
							mem_wdata = 1'b1;
							if (!ract_q) begin
								ract_d  = 1'b1;
								rtot_d  = '0;
								rbase_d = '0;
							end
							state_d = swte_pkg::ST_ADV_RD;
						end
						swte_pkg::OP_ACK: begin
							if (sen_q) begin
								if (req.acked_count > sbase_q) begin
									sbase_d = req.acked_count;
									timer_d = '0;
								end else if (req.acked_count == '0) begin
									timer_d = '0;
								end
							end
						end
						swte_pkg::OP_SYN: begin
							if (!ract_q) begin
								ract_d  = 1'b1;
								rtot_d  = (req.announced_total > swte_pkg::MAX_CHUNKS_C)
									? swte_pkg::MAX_CHUNKS_C : req.announced_total;
								rbase_d = '0;
								state_d = swte_pkg::ST_SYNACK;
							end
						end
						swte_pkg::OP_TICK: begin
							if (sen_q) begin
								if (timer_q != swte_pkg::TIMER_MAX) begin
									timer_d = timer_q + 16'd1;
								end
								cnt_d   = '0;
								state_d = swte_pkg::ST_NEW;
							end
						end
						default: ;
					endcase
				end
			end
			swte_pkg::ST_ADV_RD: begin
				rd_addr = rbase_q[swte_pkg::ADDR_W-1:0];
				if (rbase_q[swte_pkg::CNT_W-1]) begin
					state_d = swte_pkg::ST_ACK;
				end else begin
					state_d = swte_pkg::ST_ADV_CHK;
				end
			end
			swte_pkg::ST_ADV_CHK: begin
				rd_addr = rbase_q[swte_pkg::ADDR_W-1:0] + 1'b1;
				if (rd_q) begin
					rbase_d = rbase_q + 1'b1;
					if (rbase_q[swte_pkg::ADDR_W-1:0] == swte_pkg::ADDR_LAST) begin
						state_d = swte_pkg::ST_ACK;
					end
				end else begin
					state_d = swte_pkg::ST_ACK;
				end
			end
			swte_pkg::ST_ACK: begin
				if (slot_free) begin
					push        = 1'b1;
					push_action = swte_pkg::ACT_ACK;
					push_pos    = rbase_q;
					push_last   = !cmpl;
					state_d     = cmpl ? swte_pkg::ST_DONE : swte_pkg::ST_IDLE;
				end
			end
			swte_pkg::ST_DONE: begin
				if (slot_free) begin
					push        = 1'b1;
					push_action = swte_pkg::ACT_DONE;
					push_pos    = rbase_q;
					push_last   = 1'b1;
					rbase_d     = '0;
					rtot_d      = '0;
					ract_d      = 1'b0;
					clr_d       = '0;
					state_d     = swte_pkg::ST_CLEAR;
				end
			end
			swte_pkg::ST_SYNACK: begin
				if (slot_free) begin
					push        = 1'b1;
					push_action = swte_pkg::ACT_SYNACK;
					push_pos    = '0;
					push_last   = 1'b1;
					state_d     = swte_pkg::ST_IDLE;
				end
			end
			swte_pkg::ST_NEW: begin
				if (can_new) begin
					if (slot_free) begin
						push        = 1'b1;
						push_action = swte_pkg::ACT_SEND;
						push_pos    = nts_q;
						push_last   = !more_new;
						nts_d       = nts_q + 1'b1;
						timer_d     = '0;
						cnt_d       = cnt_q + 1'b1;
						if (!more_new) begin
							state_d = swte_pkg::ST_IDLE;
						end
					end
				end else if (timer_q > tmo_q) begin
					timer_d = '0;
					if (sbase_q < nts_q) begin
						idx_d   = sbase_q;
						state_d = swte_pkg::ST_RESEND;
					end else begin
						state_d = swte_pkg::ST_IDLE;
					end
				end else begin
					state_d = swte_pkg::ST_IDLE;
				end
			end
			swte_pkg::ST_RESEND: begin
				if (slot_free) begin
					push        = 1'b1;
					push_action = swte_pkg::ACT_RESEND;
					push_pos    = idx_q;
					push_last   = rs_last;
					idx_d       = idx_q + 1'b1;
					cnt_d       = cnt_q + 1'b1;
					if (rs_last) begin
						state_d = swte_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = swte_pkg::ST_IDLE;
		endcase

		if (cfg_we) begin
			case (cfg_index)
				swte_pkg::CFG_WINDOW:  win_d  = cfg_wdata[5:0];
				swte_pkg::CFG_TIMEOUT: tmo_d  = cfg_wdata;
				swte_pkg::CFG_TOTAL:   stot_d = cfg_wdata[swte_pkg::CNT_W-1:0];
				swte_pkg::CFG_ENABLE: begin
					if (cfg_wdata[0] && !sen_q) begin
						sbase_d = '0;
						nts_d   = '0;
						timer_d = '0;
					end
					sen_d = cfg_wdata[0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swte_pkg::ST_CLEAR;
			clr_q   <= '0;
			rbase_q <= '0;
			rtot_q  <= '0;
			ract_q  <= 1'b0;
			sbase_q <= '0;
			nts_q   <= '0;
			timer_q <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			win_q   <= 6'd10;
			tmo_q   <= 16'd1000;
			stot_q  <= '0;
			sen_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			rbase_q <= rbase_d;
			rtot_q  <= rtot_d;
			ract_q  <= ract_d;
			sbase_q <= sbase_d;
			nts_q   <= nts_d;
			timer_q <= timer_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			win_q   <= win_d;
			tmo_q   <= tmo_d;
			stot_q  <= stot_d;
			sen_q   <= sen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= map_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_action_q <= push_action;
			out_pos_q    <= push_pos;
			out_last_q   <= push_last;
		end
	end

	assign req.ready    = req_ready;
	assign res.valid    = out_valid_q;
	assign res.action   = out_action_q;
	assign res.position = out_pos_q;
	assign res.last     = out_last_q;

endmodule
